// File: hdl/qadt_pkg.sv
`default_nettype none

package qadt_pkg;

    localparam int MAX_DELIMITER_DEFAULT = 4;
    localparam int POSITION_BITS_DEFAULT = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_DELIMITER_BYTES  = 2'd0;
    localparam logic [1:0] REG_DELIMITER_LENGTH = 2'd1;
    localparam logic [1:0] REG_QUOTE_AWARE      = 2'd2;

    localparam logic [31:0] DELIMITER_BYTES_RESET  = 32'd44;
    localparam logic [2:0]  DELIMITER_LENGTH_RESET = 3'd1;
    localparam logic        QUOTE_AWARE_RESET      = 1'b0;

    // Locked quote kind
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    typedef struct packed {
        logic [31:0] delimiter_bytes;
        logic [2:0]  delimiter_length;
        logic        quote_aware;
    } qadt_cfg_t;

    typedef struct packed {
        logic        overflow;
        logic        final_token;
        logic [15:0] token_length;
        logic [15:0] token_start;
    } qadt_result_t;

    // Up to two tokens leave the decide logic for one byte
    typedef struct packed {
        logic [1:0]   count;
        qadt_result_t first;
        qadt_result_t second;
    } qadt_push_t;

endpackage

`default_nettype wire

// File: hdl/qadt_core.sv
`default_nettype none

module qadt_core #(
    parameter int MAX_DELIMITER = 4,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire qadt_pkg::qadt_cfg_t   cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    input  wire logic                  space_ok,
    output qadt_pkg::qadt_push_t       push
);
    import qadt_pkg::*;

    localparam int CAP = (MAX_DELIMITER < 4) ? MAX_DELIMITER : 4;
    localparam int PB  = POSITION_BITS;

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg,  in_byte_next;
    logic          in_last_reg,  in_last_next;

    logic [7:0]    win_reg [CAP];
    logic [7:0]    win_next [CAP];
    logic [2:0]    fill_reg,  fill_next;
    logic [PB-1:0] head_reg,  head_next;
    logic [PB-1:0] cs_reg,    cs_next;
    logic [PB-1:0] cl_reg,    cl_next;
    logic [1:0]    skip_reg,  skip_next;
    logic [1:0]    lq_reg,    lq_next;
    logic          ign_reg,   ign_next;
    logic          ovf_reg,   ovf_next;

    logic [2:0]    len;
    logic          fire;

    function automatic logic [15:0] low16(input logic [PB-1:0] v);
        logic [PB+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    always_comb
    begin
        if (cfg.delimiter_length == 3'd0)
            len = 3'd1;
        else if (cfg.delimiter_length > 3'(CAP))
            len = 3'(CAP);
        else
            len = cfg.delimiter_length;
    end

    assign fire     = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = in_byte;
            in_last_next  = in_last;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        logic          active;
        logic          hit;
        logic          matched;
        logic [7:0]    b;
        logic [PB-1:0] m_start;
        logic [PB-1:0] m_len;

        active  = 1'b0;
        hit     = 1'b0;
        matched = 1'b0;
        b       = 8'd0;
        m_start = cs_reg;
        m_len   = cl_reg;

        for (int i = 0; i < CAP; i++)
            win_next[i] = win_reg[i];
        fill_next = fill_reg;
        head_next = head_reg;
        cs_next   = cs_reg;
        cl_next   = cl_reg;
        skip_next = skip_reg;
        lq_next   = lq_reg;
        ign_next  = ign_reg;
        ovf_next  = ovf_reg;
        push      = '0;

        if (fire)
        begin
            ovf_next = ovf_reg | (head_reg == {PB{1'b1}});
            for (int i = CAP - 1; i > 0; i--)
                win_next[i] = win_reg[i - 1];
            win_next[0] = in_byte_reg;
            head_next = head_reg + {{(PB-1){1'b0}}, 1'b1};
            fill_next = (fill_reg < len) ? fill_reg + 3'd1 : len;

            // Oldest position first; only the one a full window back can match
            for (int off = CAP - 1; off >= 0; off--)
            begin
                if (in_last_reg)
                    active = 3'(off) < fill_next;
                else
                    active = (fill_next == len) && (3'(off) == len - 3'd1);
                if (active)
                begin
                    if (skip_next != 2'd0)
                    begin
                        skip_next = skip_next - 2'd1;
                    end
                    else
                    begin
                        b = win_next[off];
                        if (cfg.quote_aware)
                        begin
                            if (lq_next == QUOTE_NONE)
                            begin
                                if (b == CH_DQUOTE)
                                begin
                                    lq_next  = QUOTE_DOUBLE;
                                    ign_next = 1'b1;
                                end
                                else if (b == CH_SQUOTE)
                                begin
                                    lq_next  = QUOTE_SINGLE;
                                    ign_next = 1'b1;
                                end
                            end
                            else if (b == ((lq_next == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE))
                            begin
                                ign_next = !ign_next;
                            end
                        end
                        hit = !(cfg.quote_aware && ign_next) && (3'(off + 1) == len);
                        for (int k = 0; k <= off; k++)
                            if (win_next[off - k] != cfg.delimiter_bytes[8*k +: 8])
                                hit = 1'b0;
                        if (hit)
                        begin
                            matched   = 1'b1;
                            m_start   = cs_next;
                            m_len     = cl_next;
                            cs_next   = head_reg - PB'(off) + PB'(len);
                            cl_next   = '0;
                            skip_next = 2'(len - 3'd1);
                        end
                        else
                        begin
                            cl_next = cl_next + {{(PB-1){1'b0}}, 1'b1};
                        end
                    end
                end
            end

            push.first.token_start  = low16(m_start);
            push.first.token_length = low16(m_len);
            push.first.final_token  = 1'b0;
            push.first.overflow     = ovf_next;

            if (in_last_reg)
            begin
                if (matched)
                begin
                    push.count                = 2'd2;
                    push.second.token_start  = low16(cs_next);
                    push.second.token_length = low16(cl_next);
                    push.second.final_token  = 1'b1;
                    push.second.overflow     = ovf_next;
                end
                else
                begin
                    push.count              = 2'd1;
                    push.first.token_start  = low16(cs_next);
                    push.first.token_length = low16(cl_next);
                    push.first.final_token  = 1'b1;
                end
                // Start a fresh buffer
                for (int i = 0; i < CAP; i++)
                    win_next[i] = 8'd0;
                fill_next = 3'd0;
                head_next = '0;
                cs_next   = '0;
                cl_next   = '0;
                skip_next = 2'd0;
                lq_next   = QUOTE_NONE;
                ign_next  = 1'b0;
                ovf_next  = 1'b0;
            end
            else if (matched)
            begin
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            for (int i = 0; i < CAP; i++)
                win_reg[i] <= 8'd0;
            fill_reg <= 3'd0;
            head_reg <= '0;
            cs_reg   <= '0;
            cl_reg   <= '0;
            skip_reg <= 2'd0;
            lq_reg   <= QUOTE_NONE;
            ign_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            for (int i = 0; i < CAP; i++)
                win_reg[i] <= win_next[i];
            fill_reg <= fill_next;
            head_reg <= head_next;
            cs_reg   <= cs_next;
            cl_reg   <= cl_next;
            skip_reg <= skip_next;
            lq_reg   <= lq_next;
            ign_reg  <= ign_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

endmodule

`default_nettype wire

// File: hdl/qadt_fifo.sv
`default_nettype none

module qadt_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire qadt_pkg::qadt_push_t   push,
    output logic                        space_ok,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output qadt_pkg::qadt_result_t      out_item
);
    import qadt_pkg::*;

    qadt_result_t mem [4];
    logic [1:0]   wr_ptr_reg, wr_ptr_next;
    logic [1:0]   rd_ptr_reg, rd_ptr_next;
    logic [2:0]   count_reg,  count_next;
    logic         pop;

    assign out_valid = count_reg != 3'd0;
    assign pop       = out_valid && out_ready;
    assign space_ok  = count_reg <= 3'd2;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/quote_aware_delimiter_tokenizer.sv
// Splits a byte stream into tokens at a delimiter of one to four bytes and
// reports each token as its start position and length, the final token of a
// buffer (the byte with tlast) always included and flagged with tlast. With
// quote_aware set, the first double or single quote locks the quote kind and
// each occurrence of that kind toggles a mode in which delimiters are ignored.
// Rate: one byte per cycle while the token queue has room. A byte passes an
// input register, one pass of window compare and token bookkeeping, then a
// four-entry token queue; a byte leaves the input register only while the
// queue has at least two free entries. Tokens leave at one per cycle while
// m_tready is high; a byte that closes a token and the buffer yields two.
// Configuration writes are taken in any cycle and belong between buffers.
`default_nettype none

module quote_aware_delimiter_tokenizer #(
    parameter int MAX_DELIMITER = qadt_pkg::MAX_DELIMITER_DEFAULT,
    parameter int POSITION_BITS = qadt_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic             m_tlast,   // final_token
    output logic [0:0]       m_tuser,   // [0] overflow
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import qadt_pkg::*;

    qadt_cfg_t    cfg_reg, cfg_next;
    qadt_push_t   push;
    qadt_result_t out_item;
    logic         space_ok;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DELIMITER_BYTES:  cfg_next.delimiter_bytes  = cfg_data;
                REG_DELIMITER_LENGTH: cfg_next.delimiter_length = cfg_data[2:0];
                REG_QUOTE_AWARE:      cfg_next.quote_aware      = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_bytes  <= DELIMITER_BYTES_RESET;
            cfg_reg.delimiter_length <= DELIMITER_LENGTH_RESET;
            cfg_reg.quote_aware      <= QUOTE_AWARE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    qadt_core #(
        .MAX_DELIMITER (MAX_DELIMITER),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    qadt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {out_item.token_length, out_item.token_start};
    assign m_tlast = out_item.final_token;
    assign m_tuser = out_item.overflow;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qadt_pkg::*;

    localparam int          IDLE_PCT       = 37;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT    = 600000;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;
    localparam logic [7:0]  CH_COMMA       = 8'h2C;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    quote_aware_delimiter_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and expected tokens
    byte_item_t   byte_q[$];
    qadt_result_t token_q[$];
    int unsigned  items_queued = 0;
    int unsigned  items_taken = 0;
    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    logic         no_idle = 1'b0;
    logic         rx_hold_armed = 1'b0;
    int unsigned  rx_hold_count = 0;

    // Tokenizer state as the predictor sees it
    logic [31:0] delim_bytes = DELIMITER_BYTES_RESET;
    logic [2:0]  delim_len_reg = DELIMITER_LENGTH_RESET;
    logic        quote_mode = QUOTE_AWARE_RESET;
    logic [7:0]  window [4] = '{default: 8'h00};
    int unsigned fill = 0;
    logic [15:0] head = 16'd0;
    logic [15:0] tok_start = 16'd0;
    logic [15:0] tok_len = 16'd0;
    int unsigned skip = 0;
    logic [1:0]  locked = QUOTE_NONE;
    logic        ignoring = 1'b0;
    logic        overflowed = 1'b0;

    function automatic int unsigned delim_len();
        if (delim_len_reg == 3'd0)
            return 1;
        if (delim_len_reg > 3'd4)
            return 4;
        return delim_len_reg;
    endfunction

    function automatic void post_token(logic [15:0] start, logic [15:0] length, logic fin);
        qadt_result_t tok;
        tok.token_start  = start;
        tok.token_length = length;
        tok.final_token  = fin;
        tok.overflow     = overflowed;
        token_q.push_back(tok);
    endfunction

    function automatic void decide_position(int unsigned off, logic can_match,
                                            logic [15:0] pos, int unsigned len);
        logic [7:0] b;
        logic       hit;
        if (skip > 0)
        begin
            skip--;
            return;
        end
        b = window[off];
        if (quote_mode)
        begin
            if (locked == QUOTE_NONE)
            begin
                if (b == CH_DQUOTE)
                begin
                    locked   = QUOTE_DOUBLE;
                    ignoring = 1'b1;
                end
                else if (b == CH_SQUOTE)
                begin
                    locked   = QUOTE_SINGLE;
                    ignoring = 1'b1;
                end
            end
            else if (b == ((locked == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE))
                ignoring = !ignoring;
        end
        hit = 1'b0;
        if (!(quote_mode && ignoring) && can_match && off + 1 >= len)
        begin
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (window[off - k] != delim_bytes[8*k +: 8])
                    hit = 1'b0;
        end
        if (hit)
        begin
            post_token(tok_start, tok_len, 1'b0);
            tok_start = pos + 16'(len);
            tok_len   = 16'd0;
            skip      = len - 1;
        end
        else
            tok_len = tok_len + 16'd1;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        int unsigned len;
        int unsigned off;
        logic [15:0] h;
        len = delim_len();
        h   = head;
        if (h == 16'hFFFF)
            overflowed = 1'b1;
        for (int i = 3; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        head = h + 16'd1;
        fill = (fill < len) ? fill + 1 : len;
        if (last)
        begin
            // flush every undecided position, then close the buffer
            off = fill;
            while (off > 0)
            begin
                off--;
                decide_position(off, off + 1 == len, h - 16'(off), len);
            end
            post_token(tok_start, tok_len, 1'b1);
            window     = '{default: 8'h00};
            fill       = 0;
            head       = 16'd0;
            tok_start  = 16'd0;
            tok_len    = 16'd0;
            skip       = 0;
            locked     = QUOTE_NONE;
            ignoring   = 1'b0;
            overflowed = 1'b0;
        end
        else if (fill == len)
            decide_position(len - 1, 1'b1, h - 16'(len - 1), len);
    endfunction

    // Byte driver
    always @(posedge clk)
    begin
        byte_item_t pending;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    pending = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending.data;
                    s_tlast  <= pending.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (rx_hold_armed && rx_hold_count < RX_HOLD_CYCLES)
            rx_hold_count <= rx_hold_count + 1;
    end

    // Token monitor
    always @(posedge clk)
    begin
        qadt_result_t got;
        qadt_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.token_start  = m_tdata[15:0];
                got.token_length = m_tdata[31:16];
                got.final_token  = m_tlast;
                got.overflow     = m_tuser[0];
                if (token_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected token: start %0d length %0d %s %0b %s %0b",
                             $time, got.token_start, got.token_length, "final",
                             got.final_token, "overflow", got.overflow);
                end
                else
                begin
                    want = token_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: token mismatch: expected %0d/%0d/%0b/%0b, %s %0d/%0d/%0b/%0b",
                                 $time, want.token_start, want.token_length,
                                 want.final_token, want.overflow, "got",
                                 got.token_start, got.token_length,
                                 got.final_token, got.overflow);
                    end
                end
            end
            m_tready <= !(rx_hold_armed && rx_hold_count < RX_HOLD_CYCLES)
                        && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] b, logic last);
        byte_item_t it;
        it.data = b;
        it.last = last;
        byte_q.push_back(it);
        items_queued++;
    endtask

    // Random buffer: whole delimiters, lone delimiter bytes, quotes and noise
    task automatic queue_buffer(int unsigned n);
        int unsigned cnt;
        int unsigned r;
        int unsigned k;
        int unsigned dl;
        logic [7:0]  b;
        cnt = 0;
        dl  = delim_len();
        while (cnt < n)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                for (k = 0; k < dl && cnt < n; k++)
                begin
                    queue_byte(delim_bytes[8*k +: 8], cnt + 1 == n);
                    cnt++;
                end
            end
            else
            begin
                k = $urandom_range(dl - 1);
                if (r < 27)
                    b = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                else if (r < 60)
                    b = delim_bytes[8*k +: 8];
                else
                    b = 8'($urandom_range(255));
                queue_byte(b, cnt + 1 == n);
                cnt++;
            end
        end
    endtask

    task automatic queue_random(int unsigned n_items);
        int unsigned cnt;
        int unsigned len;
        cnt = 0;
        while (cnt < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(16, 1);
            queue_buffer(len);
            cnt += len;
        end
    endtask

    task automatic drain_tokens();
        while (items_taken != items_queued || token_q.size() != 0)
            @(posedge clk);
    endtask

    // Bytes that close no token may still be in flight after the last token
    task automatic wait_idle();
        drain_tokens();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DELIMITER_BYTES:  delim_bytes   = val;
            REG_DELIMITER_LENGTH: delim_len_reg = val[2:0];
            REG_QUOTE_AWARE:      quote_mode    = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] delim, logic [2:0] len, logic quoted);
        wait_idle();
        write_reg(REG_DELIMITER_BYTES, delim);
        write_reg(REG_DELIMITER_LENGTH, {29'd0, len});
        write_reg(REG_QUOTE_AWARE, {31'd0, quoted});
    endtask

    initial
    begin
        logic [7:0] b;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: single comma, plain split
        queue_byte("a", 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte("b", 1'b1);
        // lone delimiter as the last byte leaves an empty final token
        queue_byte(CH_COMMA, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();
        write_reg(REG_UNUSED, $urandom);

        // double quote locks; a single quote inside plain text then does nothing
        write_reg(REG_QUOTE_AWARE, 32'd1);
        queue_byte(CH_DQUOTE, 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte(CH_DQUOTE, 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte(CH_SQUOTE, 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte("x", 1'b1);

        // three-byte delimiter, last byte flushes a partial match
        set_config(32'h0063_6261, 3'd3, 1'b0);
        queue_byte("x", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b0);
        queue_byte("c", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b1);
        queue_byte("q", 1'b0);
        queue_byte("a", 1'b0);
        // shorten the delimiter in the middle of a buffer
        wait_idle();
        write_reg(REG_DELIMITER_LENGTH, 32'd1);
        queue_byte("a", 1'b0);
        queue_byte("z", 1'b1);

        // one long buffer, no idling on either side
        set_config({24'd0, CH_COMMA}, 3'd1, 1'b0);
        no_idle <= 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            if (i == 10 || i == 250)
                b = CH_COMMA;
            else
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_COMMA);
            end
            queue_byte(b, i == 299);
        end
        wait_idle();
        no_idle <= 1'b0;

        set_config(32'hFFFF_FFFF, 3'd4, 1'b1);
        queue_random(190);
        set_config(32'h0000_0000, 3'd1, 1'b0);
        queue_random(190);
        set_config($urandom, 3'd7, 1'b1);
        queue_random(190);
        // receiver holds off while bytes keep coming
        set_config($urandom, 3'd0, 1'b1);
        rx_hold_armed <= 1'b1;
        queue_random(190);
        set_config($urandom, 3'd2, 1'b0);
        queue_random(190);
        // sender waits for every token before going on
        set_config({16'd0, CH_COMMA, CH_DQUOTE}, 3'd2, 1'b1);
        queue_random(95);
        drain_tokens();
        queue_random(95);
        set_config($urandom, 3'd3, 1'b1);
        queue_random(190);
        set_config($urandom, 3'd5, 1'b0);
        queue_random(190);

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
hdl/qadt_pkg.sv
hdl/qadt_core.sv
hdl/qadt_fifo.sv
hdl/quote_aware_delimiter_tokenizer.sv
sim/tb_top.sv
